FILE: rtl/core/pls_pkg.sv
// Package for the pulse lag/lead shifter: field widths, register indexes,
// phase encodings and the control structs shared by the core modules.
// No dependencies.
package pls_pkg;

	localparam int SHIFT_W = 7;
	localparam int UNIT_W  = 8;
	localparam int RECAL_W = 23;
	localparam int OUT_W   = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [RECAL_W-1:0] RECAL_RESET = 23'd5000000;
	localparam logic [OUT_W-1:0]   OUT_MAX     = 20'hFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_UNIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECAL_INT  = 2'd2;

	typedef enum logic [1:0] {
		MEAS_IDLE = 2'd0,
		MEAS_HIGH = 2'd1,
		MEAS_LOW  = 2'd2
	} meas_phase_t;

	typedef enum logic [1:0] {
		EMIT_OFF  = 2'd0,
		EMIT_WAIT = 2'd1,
		EMIT_HIGH = 2'd2
	} emit_phase_t;

	typedef struct packed {
		logic signed [SHIFT_W-1:0] shift_step;
		logic [UNIT_W-1:0]         step_unit_us;
		logic [RECAL_W-1:0]        recal_interval_us;
	} cfg_regs_t;

	typedef struct packed {
		logic pulse_out;
		logic calibrating;
	} step_flags_t;

endpackage

FILE: rtl/core/pulse_lag_lead_shifter.sv
// Top level of the pulse lag/lead shifter: input register, per-tick state
// update, result register and configuration registers.
// Depends on pls_pkg, pls_cfg and pls_step.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_ready | pulse_in
//   out     | out_valid/out_ready | pulse_out, high_us, period_us, calibrating
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One tick item per cycle unless the result register stalls: an accepted
// item is held in the input register, processed by the state update and its
// result loaded into the result register, which raises out_valid. A stalled
// result register holds the input register, which still takes one item.
// Reset clears all counters and stores and sets the calibration request.
// cfg_ready is always high; writes are registered in pls_cfg.
module pulse_lag_lead_shifter #(
	parameter int COUNTER_BITS = 20,
	parameter int MAX_STEP     = 60
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             pulse_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             pulse_out,
	output logic [pls_pkg::OUT_W-1:0]        high_us,
	output logic [pls_pkg::OUT_W-1:0]        period_us,
	output logic                             calibrating,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pls_pkg::*;

	cfg_regs_t               cfg;
	step_flags_t             flags;
	logic [COUNTER_BITS-1:0] high_store, period_store;
	logic [31:0]             high_ext, period_ext;

	logic                    valid_s1, pulse_s1;
	logic                    valid_s2;
	step_flags_t             flags_s2;
	logic [OUT_W-1:0]        high_s2, period_s2;
	logic                    advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	pls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pls_step #(
		.COUNTER_BITS (COUNTER_BITS),
		.MAX_STEP     (MAX_STEP)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.level        (pulse_s1),
		.cfg          (cfg),
		.flags        (flags),
		.high_store   (high_store),
		.period_store (period_store)
	);

	// saturate the stores to the output field width
	assign high_ext   = 32'(high_store);
	assign period_ext = 32'(period_store);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			pulse_s1 <= pulse_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2  <= flags;
			high_s2   <= (high_ext > 32'(OUT_MAX)) ? OUT_MAX : high_ext[OUT_W-1:0];
			period_s2 <= (period_ext > 32'(OUT_MAX)) ? OUT_MAX : period_ext[OUT_W-1:0];
		end
	end

	assign out_valid   = valid_s2;
	assign pulse_out   = flags_s2.pulse_out;
	assign calibrating = flags_s2.calibrating;
	assign high_us     = high_s2;
	assign period_us   = period_s2;

	// calibration cancels emission and blocks new starts
	a_no_emit_while_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pulse_out && calibrating))
		else $error("pulse emitted during calibration");

	// a held input item must stay put while the result register stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pulse_s1)))
		else $error("input register lost a stalled item");

	// a full pipeline with a taking sink keeps delivering
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_ready) |=> valid_s2)
		else $error("result register emptied with an item pending");

endmodule

FILE: rtl/core/pls_cfg.sv
// Configuration register file of the pulse lag/lead shifter.
// Depends on pls_pkg for register indexes and the cfg_regs_t struct.
module pls_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pls_pkg::cfg_regs_t               cfg
);
	import pls_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.shift_step        <= '0;
			regs_q.step_unit_us      <= '0;
			regs_q.recal_interval_us <= RECAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHIFT_STEP: regs_q.shift_step <= cfg_data[SHIFT_W-1:0];
				REG_STEP_UNIT:  regs_q.step_unit_us <= cfg_data[UNIT_W-1:0];
				REG_RECAL_INT:  regs_q.recal_interval_us <= cfg_data[RECAL_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/pls_step.sv
// Per-tick state update of the pulse lag/lead shifter: calibration counters,
// recalibration timer and output emitter. Depends on pls_pkg.
module pls_step #(
	parameter int COUNTER_BITS = 20,
	parameter int MAX_STEP     = 60
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     level,
	input  pls_pkg::cfg_regs_t       cfg,
	output pls_pkg::step_flags_t     flags,
	output logic [COUNTER_BITS-1:0]  high_store,
	output logic [COUNTER_BITS-1:0]  period_store
);
	import pls_pkg::*;

	localparam int PROD_W = SHIFT_W + UNIT_W;
	localparam logic [COUNTER_BITS-1:0] CntMax = '1;
	localparam logic [SHIFT_W-1:0]      MaxStepW = SHIFT_W'(MAX_STEP);

	logic                    prev_q;
	meas_phase_t             mphase_q, mphase_n;
	logic                    req_q, req_n;
	logic [COUNTER_BITS-1:0] mcnt_q, mcnt_n;
	logic [COUNTER_BITS-1:0] high_q, high_n;
	logic [COUNTER_BITS-1:0] low_q, low_n;
	logic [COUNTER_BITS-1:0] period_q, period_n;
	emit_phase_t             ephase_q, ephase_n;
	logic [COUNTER_BITS-1:0] ecnt_q, ecnt_n;
	logic [RECAL_W-1:0]      rc_q, rc_n;

	logic                    rise, fall;
	logic [RECAL_W-1:0]      rc_inc;
	logic                    shift_neg, shift_zero;
	logic [SHIFT_W-1:0]      mag, mag_c;
	logic [PROD_W-1:0]       prod;
	logic [COUNTER_BITS-1:0] ticks, lead_delay;

	assign rise = level & ~prev_q;
	assign fall = ~level & prev_q;
	assign rc_inc = rc_q + 1'b1;

	// shift magnitude in ticks; at most MAX_STEP*255, so it never hits the counter limit
	assign shift_neg  = cfg.shift_step[SHIFT_W-1];
	assign shift_zero = (cfg.shift_step == '0);
	assign mag        = shift_neg ? SHIFT_W'(-cfg.shift_step) : SHIFT_W'(cfg.shift_step);
	assign mag_c      = (mag > MaxStepW) ? MaxStepW : mag;
	assign prod       = PROD_W'(mag_c) * PROD_W'(cfg.step_unit_us);
	assign ticks      = COUNTER_BITS'(prod);
	assign lead_delay = (low_q > ticks) ? (low_q - ticks) : '0;

	// next state
	always_comb begin
		req_n    = req_q;
		rc_n     = rc_inc;
		if (rc_inc >= cfg.recal_interval_us) begin
			req_n = 1'b1;
			rc_n  = '0;
		end

		mcnt_n = mcnt_q;
		if (mphase_q != MEAS_IDLE && mcnt_q != CntMax)
			mcnt_n = mcnt_q + 1'b1;
		ecnt_n = ecnt_q;
		if (ephase_q != EMIT_OFF && ecnt_q != '0)
			ecnt_n = ecnt_q - 1'b1;

		mphase_n = mphase_q;
		ephase_n = ephase_q;
		high_n   = high_q;
		low_n    = low_q;
		period_n = period_q;

		if (rise) begin
			if (req_n) begin
				// start calibration and cancel any emission
				mphase_n = MEAS_HIGH;
				mcnt_n   = '0;
				ephase_n = EMIT_OFF;
				ecnt_n   = '0;
			end else if (mphase_q == MEAS_LOW) begin
				period_n = mcnt_n;
				low_n    = (mcnt_n > high_q) ? (mcnt_n - high_q) : '0;
				mphase_n = MEAS_IDLE;
				mcnt_n   = '0;
			end else if (mphase_q == MEAS_IDLE) begin
				if (shift_zero) begin
					ephase_n = EMIT_WAIT;
					ecnt_n   = '0;
				end else if (!shift_neg) begin
					ephase_n = EMIT_WAIT;
					ecnt_n   = ticks;
				end
			end
		end else if (fall) begin
			if (mphase_q == MEAS_HIGH) begin
				high_n   = mcnt_n;
				req_n    = 1'b0;
				mphase_n = MEAS_LOW;
			end else if (mphase_q == MEAS_IDLE && shift_neg) begin
				ephase_n = EMIT_WAIT;
				ecnt_n   = lead_delay;
			end
		end

		// settle the emitter: wait done -> high for the stored width
		if (ephase_n == EMIT_WAIT && ecnt_n == '0) begin
			ephase_n = EMIT_HIGH;
			ecnt_n   = high_n;
		end
		if (ephase_n == EMIT_HIGH && ecnt_n == '0)
			ephase_n = EMIT_OFF;
	end

	// outputs
	always_comb begin
		flags.pulse_out   = (ephase_n == EMIT_HIGH);
		flags.calibrating = (mphase_n != MEAS_IDLE);
		high_store        = high_n;
		period_store      = period_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			mphase_q <= MEAS_IDLE;
			req_q    <= 1'b1;
			mcnt_q   <= '0;
			high_q   <= '0;
			low_q    <= '0;
			period_q <= '0;
			ephase_q <= EMIT_OFF;
			ecnt_q   <= '0;
			rc_q     <= '0;
		end else if (en) begin
			prev_q   <= level;
			mphase_q <= mphase_n;
			req_q    <= req_n;
			mcnt_q   <= mcnt_n;
			high_q   <= high_n;
			low_q    <= low_n;
			period_q <= period_n;
			ephase_q <= ephase_n;
			ecnt_q   <= ecnt_n;
			rc_q     <= rc_n;
		end
	end

endmodule
